### hdl/pqs_pkg.sv
// Shared types, constants and a helper function of the polyline stroke quad unit.
package pqs_pkg;

	localparam int COORD_W = 32;
	localparam int NORM_W = 16;
	localparam int VNUM_W = 14;
	localparam int WIDTH_W = 16;
	localparam int OFF_W = 20;
	localparam int DEF_MAX_POINTS = 4096;
	localparam logic [WIDTH_W-1:0] STROKE_RESET = 16'd256;

	// Index of the fourth vertex of a quad.
	localparam logic [1:0] VTX_LAST = 2'd3;

	// Input word: one polyline point.
	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
	} in_word_t;

	// Output word: one vertex.
	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic [VNUM_W-1:0]         vertex_number;
		logic                      last_vertex;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       latch_in;
		logic       norm_start;
		logic       norm_joint;
		logic       take_nnew;
		logic       joint_from_nnew;
		logic       take_endn;
		logic       quad_load;
		logic       quad_b;
		logic       emit;
		logic [1:0] vtx_idx;
		logic       clear;
		logic       advance;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seen_ge1;
		logic seen_ge2;
		logic last;
		logic norm_done;
		logic out_free;
	} stat_t;

	// Offset n*w rounded from Q9.22 to Q11.8, half away from zero.
	function automatic logic signed [OFF_W-1:0] scale_off(
		input logic signed [NORM_W-1:0] n,
		input logic [WIDTH_W-1:0] w
	);
		logic [NORM_W-1:0] mag;
		logic [32:0] prod;
		logic [OFF_W-1:0] r;
		mag = n[NORM_W-1] ? NORM_W'(-n) : NORM_W'(n);
		prod = 33'(mag) * 33'(w) + 33'd8192;
		r = {1'b0, prod[32:14]};
		return n[NORM_W-1] ? OFF_W'(-r) : OFF_W'(r);
	endfunction

endpackage

### hdl/polyline_stroke_quads_unit.sv
// Top level of the polyline stroker: points in, quad vertices out.
//
//  channel | direction | word
//  in      | input     | one polyline point (in_word_t)
//  out     | output    | one quad vertex (out_word_t)
//  cfg     | input     | stroke half width, unsigned Q8.8
//
// One point at a time: an accept step, a closing step and up to two normalizations,
// each made of the scaling shift, the 32-step square root and the two 15-step
// dividers side by side (a zero vector skips them), plus one load step and four
// output vertices per quad.
// Reset sets the stroke width to 1.0 and clears the polyline state.
// A stalled output holds the block in its emit step; the next point waits until then.
module polyline_stroke_quads_unit #(
	parameter int MAX_POINTS = pqs_pkg::DEF_MAX_POINTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pqs_pkg::in_word_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pqs_pkg::out_word_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pqs_pkg::WIDTH_W-1:0]   cfg_data
);

	pqs_pkg::cmd_t cmd;
	pqs_pkg::stat_t stat;

	// The width register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	pqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pqs_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### hdl/pqs_norm.sv
// Multi-cycle unit that turns a vector into a Q1.14 unit vector.
module pqs_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [33:0]                  vx,
	input  logic signed [33:0]                  vy,
	output logic                                done,
	output logic signed [pqs_pkg::NORM_W-1:0]   nx,
	output logic signed [pqs_pkg::NORM_W-1:0]   ny
);

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SUM   = 3'd3;
	localparam logic [2:0] N_ROOT  = 3'd4;
	localparam logic [2:0] N_DINIT = 3'd5;
	localparam logic [2:0] N_DIV   = 3'd6;
	localparam logic [2:0] N_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [33:0] ax_q, ay_q, mx;
	logic sx_q, sy_q;
	logic [61:0] sqx_q, sqy_q;
	logic [62:0] v_q, r_q, bit_q;
	logic [63:0] trial;
	logic [45:0] remx_q, remy_q, dsh_q;
	logic [14:0] qx_q, qy_q;
	logic [3:0] cnt_q;

	assign mx = (ax_q > ay_q) ? ax_q : ay_q;
	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign done = (state_q == N_DONE);
	assign nx = sx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
	assign ny = sy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});

	// Sequencer: scale, square, square root, then two dividers side by side; a zero vector skips to N_DONE.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= (vx == '0 && vy == '0) ? N_DONE : N_SHIFT;
					end
				end
				N_SHIFT: begin
					if (mx[33:31] == '0 && mx[30]) begin
						state_q <= N_SQ;
					end
				end
				N_SQ:    state_q <= N_SUM;
				N_SUM:   state_q <= N_ROOT;
				N_ROOT:  if (bit_q[0]) state_q <= N_DINIT;
				N_DINIT: state_q <= N_DIV;
				N_DIV:   if (cnt_q == 4'd14) state_q <= N_DONE;
				N_DONE:  state_q <= N_IDLE;
				default: state_q <= N_IDLE;
			endcase
		end
	end

	// Arithmetic registers.
	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					ax_q <= vx[33] ? 34'(-vx) : 34'(vx);
					ay_q <= vy[33] ? 34'(-vy) : 34'(vy);
					sx_q <= vx[33];
					sy_q <= vy[33];
					qx_q <= '0;
					qy_q <= '0;
				end
			end
			N_SHIFT: begin
				if (mx[33:31] != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (!mx[30]) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			N_SQ: begin
				sqx_q <= ax_q[30:0] * ax_q[30:0];
				sqy_q <= ay_q[30:0] * ay_q[30:0];
			end
			N_SUM: begin
				v_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
				r_q <= '0;
				bit_q <= 63'(1) << 62;
			end
			N_ROOT: begin
				if ({1'b0, v_q} >= trial) begin
					v_q <= v_q - trial[62:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DINIT: begin
				remx_q <= {1'b0, ax_q[30:0], 14'b0} + 46'(r_q[31:1]);
				remy_q <= {1'b0, ay_q[30:0], 14'b0} + 46'(r_q[31:1]);
				dsh_q <= {r_q[31:0], 14'b0};
				cnt_q <= '0;
			end
			N_DIV: begin
				if (remx_q >= dsh_q) begin
					remx_q <= remx_q - dsh_q;
				end
				if (remy_q >= dsh_q) begin
					remy_q <= remy_q - dsh_q;
				end
				qx_q <= {qx_q[13:0], remx_q >= dsh_q};
				qy_q <= {qy_q[13:0], remy_q >= dsh_q};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/pqs_dp.sv
// Datapath: point and normal registers, quad offsets and the output register.
module pqs_dp #(
	parameter int MAX_POINTS = pqs_pkg::DEF_MAX_POINTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pqs_pkg::in_word_t              in_data,
	input  logic                           cfg_valid,
	input  logic [pqs_pkg::WIDTH_W-1:0]    cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output pqs_pkg::out_word_t             out_data,
	input  pqs_pkg::cmd_t                  cmd,
	output pqs_pkg::stat_t                 stat
);

	localparam int SEEN_W = $clog2(MAX_POINTS + 1);
	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_POINTS);

	typedef logic signed [pqs_pkg::COORD_W-1:0] crd_t;
	typedef logic signed [pqs_pkg::NORM_W-1:0] nrm_t;

	crd_t px_q, py_q, ox_q, oy_q, nwx_q, nwy_q, q0x_q, q0y_q, q1x_q, q1y_q;
	logic plast_q, qlast_q, out_valid_q;
	nrm_t segx_q, segy_q, jx_q, jy_q, nnx_q, nny_q, enx_q, eny_q;
	nrm_t nx, ny, n0x, n0y, n1x, n1y;
	logic [SEEN_W-1:0] seen_q;
	logic [pqs_pkg::VNUM_W-1:0] vcnt_q;
	logic [pqs_pkg::WIDTH_W-1:0] width_q;
	logic signed [pqs_pkg::OFF_W-1:0] o0x_q, o0y_q, o1x_q, o1y_q;
	logic signed [33:0] vx, vy;
	logic norm_done;
	crd_t vtx_x, vtx_y;
	pqs_pkg::out_word_t out_q;

	// Vector to normalize: the new segment, or the sum of two normals at a joint.
	always_comb begin
		if (cmd.norm_joint) begin
			vx = 34'(segx_q) + 34'(nnx_q);
			vy = 34'(segy_q) + 34'(nny_q);
		end else begin
			vx = 34'(px_q) - 34'(nwx_q);
			vy = 34'(py_q) - 34'(nwy_q);
		end
	end

	pqs_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.norm_start),
		.vx     (vx),
		.vy     (vy),
		.done   (norm_done),
		.nx     (nx),
		.ny     (ny)
	);

	// Normals of the quad about to be loaded.
	assign n0x = jx_q;
	assign n0y = jy_q;
	assign n1x = cmd.quad_b ? nnx_q : enx_q;
	assign n1y = cmd.quad_b ? nny_q : eny_q;

	// Stroke width register, written through the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= pqs_pkg::STROKE_RESET;
		end else if (cfg_valid) begin
			width_q <= cfg_data;
		end
	end

	// Polyline state that reset and the end of a polyline clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0;
			oy_q <= '0;
			nwx_q <= '0;
			nwy_q <= '0;
			segx_q <= '0;
			segy_q <= '0;
			jx_q <= '0;
			jy_q <= '0;
			seen_q <= '0;
			vcnt_q <= '0;
		end else begin
			if (cmd.joint_from_nnew) begin
				jx_q <= ny;
				jy_q <= -nx;
			end else if (cmd.quad_load && !cmd.quad_b) begin
				jx_q <= enx_q;
				jy_q <= eny_q;
			end
			if (cmd.emit) begin
				vcnt_q <= vcnt_q + 1'b1;
			end
			if (cmd.clear) begin
				ox_q <= '0;
				oy_q <= '0;
				nwx_q <= '0;
				nwy_q <= '0;
				segx_q <= '0;
				segy_q <= '0;
				jx_q <= '0;
				jy_q <= '0;
				seen_q <= '0;
				vcnt_q <= '0;
			end else if (cmd.advance) begin
				segx_q <= nnx_q;
				segy_q <= nny_q;
				ox_q <= nwx_q;
				oy_q <= nwy_q;
				nwx_q <= px_q;
				nwy_q <= py_q;
				if (seen_q < SEEN_MAX) begin
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

	// Working registers: input word, new normals, quad corners and offsets.
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			px_q <= in_data.point_x;
			py_q <= in_data.point_y;
			plast_q <= in_data.last_point;
			nnx_q <= '0;
			nny_q <= '0;
		end
		if (cmd.take_nnew) begin
			nnx_q <= ny;
			nny_q <= -nx;
		end
		if (cmd.take_endn) begin
			enx_q <= nx;
			eny_q <= ny;
		end
		if (cmd.quad_load) begin
			q0x_q <= cmd.quad_b ? nwx_q : ox_q;
			q0y_q <= cmd.quad_b ? nwy_q : oy_q;
			q1x_q <= cmd.quad_b ? px_q : nwx_q;
			q1y_q <= cmd.quad_b ? py_q : nwy_q;
			qlast_q <= cmd.quad_b;
			o0x_q <= pqs_pkg::scale_off(n0x, width_q);
			o0y_q <= pqs_pkg::scale_off(n0y, width_q);
			o1x_q <= pqs_pkg::scale_off(n1x, width_q);
			o1y_q <= pqs_pkg::scale_off(n1y, width_q);
		end
	end

	// Corner of the quad selected by the vertex index.
	always_comb begin
		case (cmd.vtx_idx)
			2'd0: begin
				vtx_x = q0x_q + crd_t'(o0x_q);
				vtx_y = q0y_q + crd_t'(o0y_q);
			end
			2'd1: begin
				vtx_x = q0x_q - crd_t'(o0x_q);
				vtx_y = q0y_q - crd_t'(o0y_q);
			end
			2'd2: begin
				vtx_x = q1x_q + crd_t'(o1x_q);
				vtx_y = q1y_q + crd_t'(o1y_q);
			end
			default: begin
				vtx_x = q1x_q - crd_t'(o1x_q);
				vtx_y = q1y_q - crd_t'(o1y_q);
			end
		endcase
	end

	// Output register: holds one word until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.vertex_x <= vtx_x;
			out_q.vertex_y <= vtx_y;
			out_q.vertex_number <= vcnt_q;
			out_q.last_vertex <= qlast_q && (cmd.vtx_idx == pqs_pkg::VTX_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign stat.seen_ge1 = (seen_q != '0);
	assign stat.seen_ge2 = (seen_q > SEEN_W'(1));
	assign stat.last = plast_q;
	assign stat.norm_done = norm_done;
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

### hdl/pqs_ctrl.sv
// Controller state machine that sequences one point through the datapath.
module pqs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pqs_pkg::stat_t  stat,
	output pqs_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SEGN = 3'd1;
	localparam logic [2:0] S_SEGW = 3'd2;
	localparam logic [2:0] S_JNTN = 3'd3;
	localparam logic [2:0] S_JNTW = 3'd4;
	localparam logic [2:0] S_QLD  = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;
	localparam logic [2:0] S_FIN  = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] vi_q, vi_d;
	logic quad_b_q, quad_b_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		vi_d = vi_q;
		quad_b_d = quad_b_q;
		cmd = '0;
		cmd.quad_b = quad_b_q;
		cmd.vtx_idx = vi_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d = stat.seen_ge1 ? S_SEGN : S_FIN;
				end
			end
			S_SEGN: begin
				cmd.norm_start = 1'b1;
				state_d = S_SEGW;
			end
			S_SEGW: begin
				if (stat.norm_done) begin
					cmd.take_nnew = 1'b1;
					if (stat.seen_ge2) begin
						state_d = S_JNTN;
					end else begin
						cmd.joint_from_nnew = 1'b1;
						quad_b_d = 1'b1;
						state_d = stat.last ? S_QLD : S_FIN;
					end
				end
			end
			S_JNTN: begin
				cmd.norm_start = 1'b1;
				cmd.norm_joint = 1'b1;
				state_d = S_JNTW;
			end
			S_JNTW: begin
				if (stat.norm_done) begin
					cmd.take_endn = 1'b1;
					quad_b_d = 1'b0;
					state_d = S_QLD;
				end
			end
			S_QLD: begin
				cmd.quad_load = 1'b1;
				vi_d = '0;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					vi_d = vi_q + 2'd1;
					if (vi_q == pqs_pkg::VTX_LAST) begin
						if (!quad_b_q && stat.last) begin
							quad_b_d = 1'b1;
							state_d = S_QLD;
						end else begin
							state_d = S_FIN;
						end
					end
				end
			end
			S_FIN: begin
				cmd.clear = stat.last;
				cmd.advance = !stat.last;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vi_q <= '0;
			quad_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vi_q <= vi_d;
			quad_b_q <= quad_b_d;
		end
	end

endmodule

### hdl/pqs_checker.sv
// Port-level checks of the polyline stroker and their binding to the top level.
module pqs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input pqs_pkg::out_word_t            out_data,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// The final vertex is always the fourth corner of a quad.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last_vertex |-> out_data.vertex_number[1:0] == 2'd3)
		else $error("last vertex is not the fourth corner");

	// A point is worked on alone: no second word right after one is taken.
	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back-to-back cycles");

	// The width register never refuses a write.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind polyline_stroke_quads_unit pqs_checker u_pqs_checker (.*);
